@@ rtl/sscl_pkg.sv @@
// sscl_pkg: types and constants for the slave-serial configuration loader.
// Shared by the front, the queue, the back and the top level.
// No dependencies.
`default_nettype none

package sscl_pkg;

  // Command codes as they arrive on the op field
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_TICK  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  // Load phase, also reported as the status field
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_INIT = 3'd1,
    PH_LOADING   = 3'd2,
    PH_FLUSHING  = 3'd3,
    PH_DONE      = 3'd4,
    PH_INIT_TO   = 3'd5,
    PH_CFG_ERR   = 3'd6,
    PH_DONE_TO   = 3'd7
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_INIT_WAIT_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_FLUSH_ROUND_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_FLUSH_CLOCKS_ROUND = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [7:0]  INIT_WAIT_LIMIT_RST    = 8'd100;
  localparam logic [15:0] FLUSH_ROUND_LIMIT_RST  = 16'd1000;
  localparam logic [7:0]  FLUSH_CLOCKS_ROUND_RST = 8'd255;

  // CCLK pulses for one shifted byte
  localparam logic [7:0] CLOCKS_PER_BYTE = 8'd8;

  // Classified command, front to back
  typedef struct packed {
    logic       is_start;
    logic       is_data;
    logic       is_tick;
    logic       is_end;
    logic [7:0] data_byte;
    logic       done_level;
    logic       init_b_level;
  } cmd_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  init_wait_limit;
    logic [15:0] flush_round_limit;
    logic [7:0]  flush_clocks_per_round;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/sscl_in_if.sv @@
// sscl_in_if: command channel (valid/ready plus command fields).
// Depends on nothing.
`default_nettype none

interface sscl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic       done_level;
  logic       init_b_level;

  modport source (output valid, output op, output data_byte, output done_level,
                  output init_b_level, input ready);
  modport sink   (input valid, input op, input data_byte, input done_level,
                  input init_b_level, output ready);
endinterface

`default_nettype wire

@@ rtl/sscl_out_if.sv @@
// sscl_out_if: result channel (valid/ready plus result fields).
// Depends on nothing.
`default_nettype none

interface sscl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] serial_byte;
  logic [7:0] clock_count;
  logic       prog_pulse;

  modport source (output valid, output status, output serial_byte,
                  output clock_count, output prog_pulse, input ready);
  modport sink   (input valid, input status, input serial_byte,
                  input clock_count, input prog_pulse, output ready);
endinterface

`default_nettype wire

@@ rtl/sscl_front.sv @@
// sscl_front: accepts command transactions, decodes the op and holds the
// classified command until the queue takes it. Depends on sscl_pkg, sscl_in_if.
`default_nettype none

module sscl_front (
  input  wire logic          clk,
  input  wire logic          rst,
  sscl_in_if.sink            cmd_in,
  output sscl_pkg::cmd_t     push_cmd,
  output logic               push_valid,
  input  wire logic          push_ready
);

  logic           hold_valid;
  sscl_pkg::cmd_t hold_cmd;
  sscl_pkg::cmd_t decoded;
  logic           accept;

  // Stage is free when empty or when its entry leaves this cycle
  assign cmd_in.ready = !hold_valid || push_ready;
  assign accept       = cmd_in.valid && cmd_in.ready;

  // Op decode
  always_comb begin
    decoded              = '0;
    decoded.data_byte    = cmd_in.data_byte;
    decoded.done_level   = cmd_in.done_level;
    decoded.init_b_level = cmd_in.init_b_level;
    case (sscl_pkg::op_t'(cmd_in.op))
      sscl_pkg::OP_START: decoded.is_start = 1'b1;
      sscl_pkg::OP_DATA:  decoded.is_data  = 1'b1;
      sscl_pkg::OP_TICK:  decoded.is_tick  = 1'b1;
      sscl_pkg::OP_END:   decoded.is_end   = 1'b1;
      default:            decoded.is_end   = 1'b1;
    endcase
  end

  // Holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold_cmd <= decoded;
    end
  end

  assign push_valid = hold_valid;
  assign push_cmd   = hold_cmd;

endmodule

`default_nettype wire

@@ rtl/sscl_queue.sv @@
// sscl_queue: two-entry command queue between front and back.
// Depends on sscl_pkg.
`default_nettype none

module sscl_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sscl_pkg::cmd_t push_cmd,
  input  wire logic          push_valid,
  output logic               push_ready,
  output sscl_pkg::cmd_t     pop_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready
);

  sscl_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sscl_back.sv @@
// sscl_back: load sequencer. Executes one queued command per cycle while the
// result register is free or draining, keeps phase and wait counter, and
// registers the result. Depends on sscl_pkg, sscl_out_if.
`default_nettype none

module sscl_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sscl_pkg::cfg_t cfg,
  input  wire sscl_pkg::cmd_t pop_cmd,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  sscl_out_if.source         res_out
);

  sscl_pkg::phase_t phase;
  sscl_pkg::phase_t phase_next;
  logic [15:0]      wait_counter;
  logic [15:0]      wait_counter_next;
  logic [15:0]      cnt_inc;
  logic [7:0]       serial_next;
  logic [7:0]       clocks_next;
  logic             prog_next;
  logic             res_valid;
  logic             take;

  // Output register free or draining this cycle
  assign pop_ready = !res_valid || res_out.ready;
  assign take      = pop_valid && pop_ready;
  assign cnt_inc   = wait_counter + 16'd1;

  // Command execution
  always_comb begin
    phase_next        = phase;
    wait_counter_next = wait_counter;
    serial_next       = 8'd0;
    clocks_next       = 8'd0;
    prog_next         = 1'b0;
    if (pop_cmd.is_start) begin
      prog_next         = 1'b1;
      wait_counter_next = 16'd0;
      phase_next        = sscl_pkg::PH_WAIT_INIT;
    end else if (pop_cmd.is_data) begin
      if (phase == sscl_pkg::PH_LOADING) begin
        serial_next = pop_cmd.data_byte;
        clocks_next = sscl_pkg::CLOCKS_PER_BYTE;
        if (pop_cmd.done_level) begin
          phase_next = sscl_pkg::PH_DONE;
        end else if (!pop_cmd.init_b_level) begin
          phase_next = sscl_pkg::PH_CFG_ERR;
        end
      end
    end else if (pop_cmd.is_tick) begin
      if (phase == sscl_pkg::PH_WAIT_INIT) begin
        wait_counter_next = cnt_inc;
        if (cnt_inc >= {8'd0, cfg.init_wait_limit}) begin
          phase_next = sscl_pkg::PH_INIT_TO;
        end else if (pop_cmd.init_b_level) begin
          phase_next = sscl_pkg::PH_LOADING;
        end
      end else if (phase == sscl_pkg::PH_FLUSHING) begin
        wait_counter_next = cnt_inc;
        if (cnt_inc >= cfg.flush_round_limit) begin
          phase_next = sscl_pkg::PH_DONE_TO;
        end else if (pop_cmd.done_level) begin
          phase_next = sscl_pkg::PH_DONE;
        end else if (!pop_cmd.init_b_level) begin
          phase_next = sscl_pkg::PH_CFG_ERR;
        end else begin
          clocks_next = cfg.flush_clocks_per_round;
        end
      end
    end else if (pop_cmd.is_end) begin
      // end of data
      if (phase == sscl_pkg::PH_LOADING) begin
        wait_counter_next = 16'd0;
        phase_next        = sscl_pkg::PH_FLUSHING;
      end
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sscl_pkg::PH_IDLE;
      wait_counter <= 16'd0;
      res_valid    <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        wait_counter <= wait_counter_next;
        res_valid    <= 1'b1;
      end else if (res_out.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (take) begin
      res_out.status      <= phase_next;
      res_out.serial_byte <= serial_next;
      res_out.clock_count <= clocks_next;
      res_out.prog_pulse  <= prog_next;
    end
  end

  assign res_out.valid = res_valid;

endmodule

`default_nettype wire

@@ rtl/fpga_slave_serial_config_loader_unit.sv @@
// Slave-serial configuration loader, top level: front decode, command queue,
// back sequencer and configuration registers.
// A command passes the front register, a queue entry and the result register
// before its result is valid. Throughput: one command per cycle while the
// result channel is not stalled; the queue absorbs short output stalls.
// Reset (synchronous): phase idle, wait counter zero, queue empty, registers
// to 100 / 1000 / 255.
`default_nettype none

module fpga_slave_serial_config_loader_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  sscl_in_if.sink                                cmd_in,
  sscl_out_if.source                             res_out,
  input  wire logic                              cfg_we,
  input  wire logic [sscl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [sscl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  sscl_pkg::cfg_t cfg;
  sscl_pkg::cmd_t push_cmd;
  sscl_pkg::cmd_t pop_cmd;
  logic           push_valid;
  logic           push_ready;
  logic           pop_valid;
  logic           pop_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_wait_limit        <= sscl_pkg::INIT_WAIT_LIMIT_RST;
      cfg.flush_round_limit      <= sscl_pkg::FLUSH_ROUND_LIMIT_RST;
      cfg.flush_clocks_per_round <= sscl_pkg::FLUSH_CLOCKS_ROUND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sscl_pkg::CFG_INIT_WAIT_LIMIT:    cfg.init_wait_limit        <= cfg_wdata[7:0];
        sscl_pkg::CFG_FLUSH_ROUND_LIMIT:  cfg.flush_round_limit      <= cfg_wdata;
        sscl_pkg::CFG_FLUSH_CLOCKS_ROUND: cfg.flush_clocks_per_round <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  sscl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_in     (cmd_in),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  sscl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  sscl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .res_out   (res_out)
  );

`ifndef SYNTH
  // A PROG pulse always restarts into wait init with no clocks
  a_prog_restart: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.prog_pulse) |->
      (res_out.status == sscl_pkg::PH_WAIT_INIT && res_out.clock_count == 8'd0))
    else $error("prog pulse without restart into wait init");

  // A nonzero shifted byte always comes with a clock count of CLOCKS_PER_BYTE
  a_byte_clocks: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.serial_byte != 8'd0) |->
      (res_out.clock_count == sscl_pkg::CLOCKS_PER_BYTE))
    else $error("shifted byte without eight clocks");

  // Flush bursts only leave the phase at flushing
  a_flush_burst: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.clock_count != 8'd0 &&
     res_out.clock_count != sscl_pkg::CLOCKS_PER_BYTE) |->
      (res_out.status == sscl_pkg::PH_FLUSHING))
    else $error("clock burst outside flushing");
`endif

endmodule

`default_nettype wire

@@ tb/tb_fpga_slave_serial_config_loader_unit.sv @@
// Testbench for the slave-serial configuration loader: self-checking, with its own prediction
// of each command's result. Depends on sscl_pkg, sscl_in_if, sscl_out_if and the top level.
`timescale 1ns / 1ps

module tb_fpga_slave_serial_config_loader_unit;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // index beyond the register list, writes to it must change nothing
  localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_ALTERNATE,
    STALL_RANDOM,
    STALL_LONG
  } stall_mode_t;

  typedef struct packed {
    sscl_pkg::phase_t status;
    logic [7:0]       serial_byte;
    logic [7:0]       clock_count;
    logic             prog_pulse;
  } loader_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [sscl_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sscl_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sscl_in_if  cmd_if ();
  sscl_out_if res_if ();

  fpga_slave_serial_config_loader_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_in   (cmd_if),
    .res_out  (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Loader state as predicted
  sscl_pkg::phase_t ph = sscl_pkg::PH_IDLE;
  logic [15:0] wait_cnt = '0;
  logic        load_done = 1'b0;
  logic [7:0]  cfg_init_limit = sscl_pkg::INIT_WAIT_LIMIT_RST;
  logic [15:0] cfg_flush_limit = sscl_pkg::FLUSH_ROUND_LIMIT_RST;
  logic [7:0]  cfg_flush_clocks = sscl_pkg::FLUSH_CLOCKS_ROUND_RST;

  loader_result_t expected_results[$];

  int unsigned err_count = 0;
  int unsigned sent_count = 0;
  int unsigned results_checked = 0;
  int unsigned settings_count = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_tick = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("fpga_slave_serial_config_loader_unit verification failed");
      $finish;
    end
  end

  // Result side back-pressure in a randomly chosen stall mode
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0)
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:      res_if.ready <= 1'b1;
      STALL_ALTERNATE: res_if.ready <= stall_tick[0];
      STALL_RANDOM:    res_if.ready <= ($urandom_range(0, 9) < 7);
      default:         res_if.ready <= (stall_tick[4:3] == 2'b00);
    endcase
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    err_count++;
  endtask

  // Result checker: oldest expectation first
  always @(posedge clk) begin : result_check
    loader_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no command pending", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (res_if.status !== want.status)
          report_mismatch("status", 32'(res_if.status), 32'(want.status));
        if (res_if.serial_byte !== want.serial_byte)
          report_mismatch("serial_byte", 32'(res_if.serial_byte), 32'(want.serial_byte));
        if (res_if.clock_count !== want.clock_count)
          report_mismatch("clock_count", 32'(res_if.clock_count), 32'(want.clock_count));
        if (res_if.prog_pulse !== want.prog_pulse)
          report_mismatch("prog_pulse", 32'(res_if.prog_pulse), 32'(want.prog_pulse));
        results_checked++;
      end
    end
  end

  // One command step of the loader: updates the predicted state, returns the result
  function automatic loader_result_t predict_step(input sscl_pkg::op_t op,
                                                  input logic [7:0] data_val,
                                                  input logic done_hi, input logic init_hi);
    loader_result_t r;
    r.serial_byte = 8'd0;
    r.clock_count = 8'd0;
    r.prog_pulse  = 1'b0;
    case (op)
      sscl_pkg::OP_START: begin
        r.prog_pulse = 1'b1;
        load_done = 1'b0;
        wait_cnt = '0;
        ph = sscl_pkg::PH_WAIT_INIT;
      end
      sscl_pkg::OP_DATA: begin
        if (ph == sscl_pkg::PH_LOADING) begin
          r.serial_byte = data_val;
          r.clock_count = sscl_pkg::CLOCKS_PER_BYTE;
          if (done_hi) begin
            load_done = 1'b1;
            ph = sscl_pkg::PH_DONE;
          end else if (!init_hi) begin
            ph = sscl_pkg::PH_CFG_ERR;
          end
        end
      end
      sscl_pkg::OP_TICK: begin
        if (ph == sscl_pkg::PH_WAIT_INIT) begin
          wait_cnt = wait_cnt + 16'd1;
          if (wait_cnt >= {8'd0, cfg_init_limit})
            ph = sscl_pkg::PH_INIT_TO;
          else if (init_hi)
            ph = sscl_pkg::PH_LOADING;
        end else if (ph == sscl_pkg::PH_FLUSHING) begin
          wait_cnt = wait_cnt + 16'd1;
          if (wait_cnt >= cfg_flush_limit) begin
            ph = sscl_pkg::PH_DONE_TO;
          end else if (done_hi) begin
            load_done = 1'b1;
            ph = sscl_pkg::PH_DONE;
          end else if (!init_hi) begin
            ph = sscl_pkg::PH_CFG_ERR;
          end else begin
            r.clock_count = cfg_flush_clocks;
          end
        end
      end
      default: begin
        if (ph == sscl_pkg::PH_LOADING) begin
          wait_cnt = '0;
          ph = sscl_pkg::PH_FLUSHING;
        end
      end
    endcase
    r.status = ph;
    return r;
  endfunction

  // Send one command; the sender runs in bursts with random gaps between them
  task automatic send_cmd(input sscl_pkg::op_t op, input logic [7:0] data_val,
                          input logic done_val, input logic init_val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.op           <= op;
    cmd_if.data_byte    <= data_val;
    cmd_if.done_level   <= done_val;
    cmd_if.init_b_level <= init_val;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    expected_results.push_back(predict_step(op, data_val, done_val, init_val));
    burst_left--;
    sent_count++;
  endtask

  task automatic send_noise();
    send_cmd(sscl_pkg::op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
             1'($urandom));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_pipeline();
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sscl_pkg::CFG_INIT_WAIT_LIMIT:    cfg_init_limit = val[7:0];
      sscl_pkg::CFG_FLUSH_ROUND_LIMIT:  cfg_flush_limit = val;
      sscl_pkg::CFG_FLUSH_CLOCKS_ROUND: cfg_flush_clocks = val[7:0];
      default: ;
    endcase
  endtask

  // Register writes only with the loader idle
  task automatic apply_settings(input logic [15:0] init_w, input logic [15:0] flush_w,
                                input logic [15:0] clocks_w);
    drain_pipeline();
    write_reg(sscl_pkg::CFG_INIT_WAIT_LIMIT, init_w);
    write_reg(sscl_pkg::CFG_FLUSH_ROUND_LIMIT, flush_w);
    write_reg(sscl_pkg::CFG_FLUSH_CLOCKS_ROUND, clocks_w);
    write_reg(CFG_SPARE_INDEX, 16'($urandom));
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // Data, tick and end of data before any start
  task automatic test_idle_commands();
    send_cmd(sscl_pkg::OP_DATA, 8'hC3, 1'b1, 1'b0);
    send_cmd(sscl_pkg::OP_TICK, 8'hFF, 1'b1, 1'b1);
    send_cmd(sscl_pkg::OP_END, 8'h00, 1'b0, 1'b1);
  endtask

  // Full load through flush to done, then commands after done
  task automatic test_basic_load();
    send_cmd(sscl_pkg::OP_START, 8'hFF, 1'b1, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_DATA, 8'hFF, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_DATA, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_END, 8'hAA, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b1, 1'b1);
    send_cmd(sscl_pkg::OP_DATA, 8'h5A, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b1, 1'b1);
    send_cmd(sscl_pkg::OP_END, 8'h00, 1'b0, 1'b1);
  endtask

  // INIT_B low while loading and flushing, DONE taking priority, restart from error
  task automatic test_error_paths();
    send_cmd(sscl_pkg::OP_START, 8'h00, 1'b0, 1'b0);
    send_cmd(sscl_pkg::OP_DATA, 8'h99, 1'b1, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_DATA, 8'h81, 1'b0, 1'b0);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_START, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_DATA, 8'h7E, 1'b1, 1'b0);
    send_cmd(sscl_pkg::OP_START, 8'h00, 1'b1, 1'b0);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b1, 1'b1);
    send_cmd(sscl_pkg::OP_END, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
  endtask

  // Limits of zero time out at once; zero flush clocks give an empty round
  task automatic test_zero_limits();
    apply_settings(16'd0, 16'd0, 16'd0);
    send_cmd(sscl_pkg::OP_START, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    apply_settings(16'd2, 16'd0, 16'd0);
    send_cmd(sscl_pkg::OP_START, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_END, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b1, 1'b1);
    apply_settings(16'd3, 16'd2, 16'd0);
    send_cmd(sscl_pkg::OP_START, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_END, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    send_cmd(sscl_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
  endtask

  // Mostly well-formed loads with random content and endings, plus random noise
  task automatic test_random_loads(input int unsigned n_items);
    int unsigned first;
    int unsigned k;
    int unsigned m;
    int unsigned fate;
    logic last;
    first = sent_count;
    while (sent_count - first < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        send_cmd(sscl_pkg::OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
        // ticks with INIT_B still low, sometimes enough to time out
        if (cfg_init_limit <= 16 && $urandom_range(0, 9) == 0)
          k = 32'(cfg_init_limit);
        else
          k = $urandom_range(0, 3);
        repeat (k) send_cmd(sscl_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'b0);
        send_cmd(sscl_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'b1);
        // bitstream bytes; the last may see DONE or a low INIT_B
        m = $urandom_range(1, 10);
        fate = $urandom_range(0, 99);
        for (int i = 0; i < m; i++) begin
          last = (i == m - 1);
          send_cmd(sscl_pkg::OP_DATA, 8'($urandom), last && fate < 15,
                   !(last && fate >= 15 && fate < 22));
        end
        if (fate >= 22) begin
          send_cmd(sscl_pkg::OP_END, 8'($urandom), 1'($urandom), 1'($urandom));
          if (cfg_flush_limit <= 24 && $urandom_range(0, 9) == 0)
            k = 32'(cfg_flush_limit);
          else
            k = $urandom_range(0, 4);
          repeat (k) send_cmd(sscl_pkg::OP_TICK, 8'($urandom), 1'b0, 1'b1);
          if ($urandom_range(0, 9) == 0)
            send_cmd(sscl_pkg::OP_TICK, 8'($urandom), 1'b0, 1'b0);
          else
            send_cmd(sscl_pkg::OP_TICK, 8'($urandom), 1'b1, 1'($urandom));
        end
        repeat ($urandom_range(0, 2)) send_noise();
      end else begin
        repeat ($urandom_range(1, 6)) send_noise();
      end
    end
  endtask

  // Random traffic under reset values, the largest settings, settings of one and random small limits
  task automatic test_settings_sweep();
    logic [15:0] iw;
    logic [15:0] fw;
    logic [15:0] cw;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin
          iw = 16'(sscl_pkg::INIT_WAIT_LIMIT_RST);
          fw = sscl_pkg::FLUSH_ROUND_LIMIT_RST;
          cw = 16'(sscl_pkg::FLUSH_CLOCKS_ROUND_RST);
        end
        1: begin
          iw = 16'd255;
          fw = 16'd65535;
          cw = 16'd255;
        end
        2: begin
          iw = 16'd1;
          fw = 16'd1;
          cw = 16'd1;
        end
        default: begin
          iw = 16'($urandom_range(2, 8));
          fw = 16'($urandom_range(1, 12));
          cw = 16'($urandom_range(0, 255));
        end
      endcase
      // upper bits of the 8-bit registers carry junk that must be dropped
      apply_settings({8'($urandom), iw[7:0]}, fw, {8'($urandom), cw[7:0]});
      test_random_loads(120);
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= sscl_pkg::CFG_INIT_WAIT_LIMIT;
    cfg_wdata           <= '0;
    cmd_if.valid        <= 1'b0;
    cmd_if.op           <= sscl_pkg::OP_TICK;
    cmd_if.data_byte    <= 8'd0;
    cmd_if.done_level   <= 1'b0;
    cmd_if.init_b_level <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_commands();
    test_basic_load();
    test_error_paths();
    test_zero_limits();
    test_settings_sweep();
    drain_pipeline();

    $display("%0d commands sent, %0d results checked, %0d register settings applied",
             sent_count, results_checked, settings_count);
    $display("covered: full loads, init and DONE timeouts, config errors, ignored commands");
    if (err_count == 0) begin
      $display("fpga_slave_serial_config_loader_unit verification clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("fpga_slave_serial_config_loader_unit verification failed");
    end
    $finish;
  end

endmodule
